FILE: hdl/pli_pkg.sv
package pli_pkg;

  // Sequencer of the multiply-divide unit
  typedef enum logic [2:0] {
    MD_IDLE,
    MD_PREP,
    MD_MUL,
    MD_CHK,
    MD_DIV,
    MD_SGN,
    MD_SUM
  } md_state_t;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

  // Input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Multiplier operand slice per cycle
  localparam int MUL_CHUNK = 16;

  // Flags that travel with a query token along the cell chain
  typedef struct packed {
    logic valid;
    logic found;
    logic oor;
  } srch_flags_t;

  // Per-cell role within the nodes in use
  typedef struct packed {
    logic first;
    logic last;
    logic active;
  } cell_ctl_t;

endpackage

FILE: hdl/piecewise_linear_interpolator_core.sv
// Channel   | Signals                                          | Beat taken when
// ----------+--------------------------------------------------+------------------------
// input     | start, busy, op, node_index, node_x, node_y,     | start && !busy
//           | query_x                                          |
// config    | cfg_valid, cfg_ready, node_count                 | cfg_valid && cfg_ready
// result    | result_valid, result_y, status                   | result_valid (one cycle)
//
// A node write beat keeps busy low. A query walks the cell chain one cell per
// cycle, then the multiply-divide unit multiplies the interval and divides;
// busy stays high until the result strobe, and an out-of-range or zero-width
// query skips the multiply and divide. Synchronous reset clears control state
// and sets node_count to 2; node contents are undefined until written. The
// receiver cannot stall.
module piecewise_linear_interpolator_core #(
  parameter int MAX_NODES   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [3:0]                    node_index,
  input  logic signed [VALUE_WIDTH-1:0] node_x,
  input  logic signed [VALUE_WIDTH-1:0] node_y,
  input  logic signed [VALUE_WIDTH-1:0] query_x,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [4:0]                    node_count,
  output logic                          result_valid,
  output logic signed [VALUE_WIDTH-1:0] result_y,
  output logic [1:0]                    status
);

  localparam int IW  = $clog2(MAX_NODES);
  localparam int NWR = $clog2(MAX_NODES + 1);
  localparam int NW  = (NWR > 5) ? NWR : 5;

  logic [4:0]    count;
  logic [NW-1:0] count_ext;
  logic [NW-1:0] count_cl;
  logic [IW-1:0] last_idx;
  logic          in_beat;
  logic          query_beat;
  logic          write_beat;

  // Chain links: entry 0 feeds the first cell, entry MAX_NODES leaves the last
  pli_pkg::srch_flags_t          flg [MAX_NODES+1];
  logic signed [VALUE_WIDTH-1:0] qv  [MAX_NODES+1];
  logic signed [VALUE_WIDTH-1:0] pxv [MAX_NODES+1];
  logic signed [VALUE_WIDTH-1:0] pyv [MAX_NODES+1];
  logic signed [VALUE_WIDTH-1:0] x1v [MAX_NODES+1];
  logic signed [VALUE_WIDTH-1:0] y1v [MAX_NODES+1];
  logic signed [VALUE_WIDTH-1:0] x2v [MAX_NODES+1];
  logic signed [VALUE_WIDTH-1:0] y2v [MAX_NODES+1];

  assign in_beat    = start && !busy;
  assign query_beat = in_beat && (op == pli_pkg::OP_QUERY);
  assign write_beat = in_beat && (op == pli_pkg::OP_WRITE);
  assign cfg_ready  = !busy;

  // Hold the node count register; take a write only between queries
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 5'd2;
    end else if (cfg_valid && cfg_ready) begin
      count <= node_count;
    end
  end

  // Clamp the count to the table size, never below two nodes
  assign count_ext = NW'(count);
  always_comb begin
    if (count_ext < NW'(2)) begin
      count_cl = NW'(2);
    end else if (count_ext > NW'(MAX_NODES)) begin
      count_cl = NW'(MAX_NODES);
    end else begin
      count_cl = count_ext;
    end
  end
  assign last_idx = IW'(count_cl - NW'(1));

  // Raise busy on a query beat, drop it with the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (query_beat) begin
      busy <= 1'b1;
    end else if (result_valid) begin
      busy <= 1'b0;
    end
  end

  // Inject the query token at the head of the chain
  assign flg[0] = '{valid: query_beat, found: 1'b0, oor: 1'b0};
  assign qv[0]  = query_x;
  assign pxv[0] = '0;
  assign pyv[0] = '0;
  assign x1v[0] = '0;
  assign y1v[0] = '0;
  assign x2v[0] = '0;
  assign y2v[0] = '0;

  for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
    localparam logic [IW-1:0] KI = IW'(k);
    pli_pkg::cell_ctl_t ctl;
    logic               wr_en;

    assign ctl.first  = (k == 0);
    assign ctl.last   = (KI == last_idx);
    assign ctl.active = (KI <= last_idx);
    // Decode the node write to this cell; indexes past the table drop
    assign wr_en      = write_beat && (int'(node_index) == k);

    pli_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en),
      .wr_x     (node_x),
      .wr_y     (node_y),
      .ctl      (ctl),
      .flags_in (flg[k]),
      .q_in     (qv[k]),
      .px_in    (pxv[k]),
      .py_in    (pyv[k]),
      .x1_in    (x1v[k]),
      .y1_in    (y1v[k]),
      .x2_in    (x2v[k]),
      .y2_in    (y2v[k]),
      .flags_out(flg[k+1]),
      .q_out    (qv[k+1]),
      .px_out   (pxv[k+1]),
      .py_out   (pyv[k+1]),
      .x1_out   (x1v[k+1]),
      .y1_out   (y1v[k+1]),
      .x2_out   (x2v[k+1]),
      .y2_out   (y2v[k+1])
    );
  end

  // Interval from the chain tail goes to the shared multiply-divide unit
  pli_muldiv #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_muldiv (
    .clk     (clk),
    .rst     (rst),
    .flags   (flg[MAX_NODES]),
    .q       (qv[MAX_NODES]),
    .x1      (x1v[MAX_NODES]),
    .y1      (y1v[MAX_NODES]),
    .x2      (x2v[MAX_NODES]),
    .y2      (y2v[MAX_NODES]),
    .done    (result_valid),
    .result_y(result_y),
    .status  (status)
  );

endmodule

FILE: hdl/pli_cell.sv
module pli_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic signed [VALUE_WIDTH-1:0] wr_x,
  input  logic signed [VALUE_WIDTH-1:0] wr_y,
  input  pli_pkg::cell_ctl_t            ctl,
  input  pli_pkg::srch_flags_t          flags_in,
  input  logic signed [VALUE_WIDTH-1:0] q_in,
  input  logic signed [VALUE_WIDTH-1:0] px_in,
  input  logic signed [VALUE_WIDTH-1:0] py_in,
  input  logic signed [VALUE_WIDTH-1:0] x1_in,
  input  logic signed [VALUE_WIDTH-1:0] y1_in,
  input  logic signed [VALUE_WIDTH-1:0] x2_in,
  input  logic signed [VALUE_WIDTH-1:0] y2_in,
  output pli_pkg::srch_flags_t          flags_out,
  output logic signed [VALUE_WIDTH-1:0] q_out,
  output logic signed [VALUE_WIDTH-1:0] px_out,
  output logic signed [VALUE_WIDTH-1:0] py_out,
  output logic signed [VALUE_WIDTH-1:0] x1_out,
  output logic signed [VALUE_WIDTH-1:0] y1_out,
  output logic signed [VALUE_WIDTH-1:0] x2_out,
  output logic signed [VALUE_WIDTH-1:0] y2_out
);

  logic signed [VALUE_WIDTH-1:0] node_x;
  logic signed [VALUE_WIDTH-1:0] node_y;
  pli_pkg::srch_flags_t          flags_next;
  logic signed [VALUE_WIDTH-1:0] x1_next;
  logic signed [VALUE_WIDTH-1:0] y1_next;
  logic signed [VALUE_WIDTH-1:0] x2_next;
  logic signed [VALUE_WIDTH-1:0] y2_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_x <= wr_x;
      node_y <= wr_y;
    end
  end

  // First cell opens the range check; later cells close the first interval
  // whose upper node is not below the query; the last cell in use closes one if none has.
  always_comb begin
    flags_next = flags_in;
    x1_next    = x1_in;
    y1_next    = y1_in;
    x2_next    = x2_in;
    y2_next    = y2_in;
    if (ctl.first) begin
      flags_next.found = 1'b0;
      flags_next.oor   = (q_in < node_x);
    end else if (ctl.active && !flags_in.found && ((q_in <= node_x) || ctl.last)) begin
      flags_next.found = 1'b1;
      x1_next          = px_in;
      y1_next          = py_in;
      x2_next          = node_x;
      y2_next          = node_y;
    end
    if (ctl.active && ctl.last) begin
      flags_next.oor = flags_next.oor | (q_in > node_x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_out.valid <= 1'b0;
    end else begin
      flags_out <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    q_out  <= q_in;
    px_out <= node_x;
    py_out <= node_y;
    x1_out <= x1_next;
    y1_out <= y1_next;
    x2_out <= x2_next;
    y2_out <= y2_next;
  end

endmodule

FILE: hdl/pli_muldiv.sv
module pli_muldiv #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pli_pkg::srch_flags_t          flags,
  input  logic signed [VALUE_WIDTH-1:0] q,
  input  logic signed [VALUE_WIDTH-1:0] x1,
  input  logic signed [VALUE_WIDTH-1:0] y1,
  input  logic signed [VALUE_WIDTH-1:0] x2,
  input  logic signed [VALUE_WIDTH-1:0] y2,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] result_y,
  output logic [1:0]                    status
);

  localparam int VW     = VALUE_WIDTH;
  localparam int DW     = VW + 1;
  localparam int CW     = pli_pkg::MUL_CHUNK;
  localparam int NCH    = (DW + CW - 1) / CW;
  localparam int BW     = NCH * CW;
  localparam int PRW    = 2 * DW;
  localparam int QW     = VW + (VW % 2);
  localparam int HW     = PRW - QW;
  localparam int RW     = VW + 2;
  localparam int DSTEPS = QW / 2;
  localparam int MCW    = $clog2(NCH + 1);
  localparam int DCW    = $clog2(DSTEPS + 1);

  localparam logic [VW-1:0] LIM_POS = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] LIM_NEG = {1'b1, {(VW-1){1'b0}}};

  pli_pkg::md_state_t state;
  pli_pkg::md_state_t state_next;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] dd;
  logic signed [VW-1:0] y1r;
  logic                 oor_r;
  logic [DW-1:0]        am;
  logic [DW-1:0]        dm;
  logic [BW-1:0]        bm_sh;
  logic                 neg;
  logic [PRW-1:0]       acc;
  logic [MCW-1:0]       mcnt;
  logic [RW-1:0]        rem;
  logic [QW-1:0]        lo;
  logic [QW-1:0]        quot;
  logic [DCW-1:0]       dcnt;
  logic                 sat;
  logic signed [DW-1:0] qs;

  logic [HW-1:0]        hi;
  logic [RW-1:0]        rem_next;
  logic [QW-1:0]        lo_next;
  logic [QW-1:0]        quot_next;
  logic [VW-1:0]        lim;
  logic [VW-1:0]        qm;
  logic signed [RW-1:0] sum;

  assign hi  = acc[PRW-1:QW];
  assign lim = neg ? LIM_NEG : LIM_POS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pli_pkg::MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pli_pkg::MD_IDLE: if (flags.valid) state_next = pli_pkg::MD_PREP;
      pli_pkg::MD_PREP: begin
        if (oor_r || (dd == '0)) begin
          state_next = pli_pkg::MD_IDLE;
        end else begin
          state_next = pli_pkg::MD_MUL;
        end
      end
      pli_pkg::MD_MUL:  if (mcnt == '0) state_next = pli_pkg::MD_CHK;
      pli_pkg::MD_CHK:  state_next = pli_pkg::MD_DIV;
      pli_pkg::MD_DIV:  if (dcnt == '0) state_next = pli_pkg::MD_SGN;
      pli_pkg::MD_SGN:  state_next = pli_pkg::MD_SUM;
      pli_pkg::MD_SUM:  state_next = pli_pkg::MD_IDLE;
      default:          state_next = pli_pkg::MD_IDLE;
    endcase
  end

  // Two restoring division steps per cycle
  always_comb begin
    rem_next  = rem;
    lo_next   = lo;
    quot_next = quot;
    for (int s = 0; s < 2; s++) begin
      rem_next = {rem_next[RW-2:0], lo_next[QW-1]};
      lo_next  = lo_next << 1;
      if (rem_next >= RW'(dm)) begin
        rem_next  = rem_next - RW'(dm);
        quot_next = {quot_next[QW-2:0], 1'b1};
      end else begin
        quot_next = {quot_next[QW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (sat || (quot > QW'(lim))) begin
      qm = lim;
    end else begin
      qm = quot[VW-1:0];
    end
  end

  assign sum = RW'(y1r) + RW'(qs);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == pli_pkg::MD_PREP) && (oor_r || (dd == '0)))
              || (state == pli_pkg::MD_SUM);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pli_pkg::MD_IDLE: begin
        dx    <= DW'(q) - DW'(x1);
        dy    <= DW'(y2) - DW'(y1);
        dd    <= DW'(x2) - DW'(x1);
        y1r   <= y1;
        oor_r <= flags.oor;
      end
      pli_pkg::MD_PREP: begin
        am    <= dx[DW-1] ? DW'(-dx) : DW'(dx);
        bm_sh <= BW'(dy[DW-1] ? DW'(-dy) : DW'(dy));
        dm    <= dd[DW-1] ? DW'(-dd) : DW'(dd);
        neg   <= dx[DW-1] ^ dy[DW-1] ^ dd[DW-1];
        acc   <= '0;
        mcnt  <= MCW'(NCH - 1);
        if (oor_r) begin
          result_y <= '0;
          status   <= pli_pkg::ST_RANGE;
        end else if (dd == '0) begin
          result_y <= '0;
          status   <= pli_pkg::ST_DEGEN;
        end
      end
      pli_pkg::MD_MUL: begin
        // Most significant slice first, shift the partial sum up
        acc   <= (acc << CW) + (PRW'(am) * PRW'(bm_sh[BW-1 -: CW]));
        bm_sh <= bm_sh << CW;
        mcnt  <= mcnt - MCW'(1);
      end
      pli_pkg::MD_CHK: begin
        sat  <= (hi >= HW'(dm));
        rem  <= RW'(hi);
        lo   <= acc[QW-1:0];
        quot <= '0;
        dcnt <= DCW'(DSTEPS - 1);
      end
      pli_pkg::MD_DIV: begin
        rem  <= rem_next;
        lo   <= lo_next;
        quot <= quot_next;
        dcnt <= dcnt - DCW'(1);
      end
      pli_pkg::MD_SGN: begin
        qs <= neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
      end
      pli_pkg::MD_SUM: begin
        if ((sum[RW-1:VW-1] == '0) || (sum[RW-1:VW-1] == '1)) begin
          result_y <= sum[VW-1:0];
        end else if (sum[RW-1]) begin
          result_y <= LIM_NEG;
        end else begin
          result_y <= LIM_POS;
        end
        status <= pli_pkg::ST_OK;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int     NODES           = 16;
  localparam int     VW              = 32;
  localparam int     ITEMS_PER_PHASE = 195;
  localparam int     PHASES          = 10;
  // Settle a bit longer than a query holds the core.
  localparam int     SETTLE          = 48;
  localparam int     CYCLE_LIMIT     = 800000;
  localparam longint VAL_MAX         = 64'sd2147483647;
  localparam longint VAL_MIN         = -64'sd2147483648;

  // One command beat as the driver puts it on the ports.
  typedef struct packed {
    logic          op;
    logic [3:0]    idx;
    logic [VW-1:0] nx;
    logic [VW-1:0] ny;
    logic [VW-1:0] qx;
  } interp_cmd_t;

  // One predicted result beat.
  typedef struct packed {
    logic [VW-1:0] y;
    logic [1:0]    st;
  } interp_res_t;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 start      = 1'b0;
  logic                 op         = pli_pkg::OP_WRITE;
  logic [3:0]           node_index = '0;
  logic signed [VW-1:0] node_x     = '0;
  logic signed [VW-1:0] node_y     = '0;
  logic signed [VW-1:0] query_x    = '0;
  logic                 cfg_valid  = 1'b0;
  logic [4:0]           node_count = 5'd2;
  logic                 busy;
  logic                 cfg_ready;
  logic                 result_valid;
  logic signed [VW-1:0] result_y;
  logic [1:0]           status;

  // Breakpoint table and node count as the core should hold them.
  logic signed [VW-1:0] x_knots [NODES];
  logic signed [VW-1:0] y_knots [NODES];
  logic [4:0]           count_reg = 5'd2;

  // Abscissas as the stimulus generator has queued them; used to aim queries.
  logic signed [VW-1:0] plan_x [NODES];

  interp_cmd_t queued_cmds [$];
  interp_res_t expected_results [$];

  int issued_cnt = 0;
  int taken_cnt  = 0;
  int fail_cnt   = 0;
  int cycle_cnt  = 0;
  int count_plan [PHASES] = '{16, 2, 5, 0, 31, 9, 1, 17, 16, 3};

  piecewise_linear_interpolator_core #(
    .MAX_NODES  (NODES),
    .VALUE_WIDTH(VW)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .node_index  (node_index),
    .node_x      (node_x),
    .node_y      (node_y),
    .query_x     (query_x),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .node_count  (node_count),
    .result_valid(result_valid),
    .result_y    (result_y),
    .status      (status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Interpolate at qx over the current table. Differences and the product are
  // carried exactly in 66 bits; the quotient truncates toward zero, then both
  // the quotient and the final sum clamp to the signed 32-bit range.
  function automatic interp_res_t interp_predict(input logic signed [VW-1:0] qx);
    interp_res_t            r;
    int                     n;
    int                     seg;
    logic signed [2*VW+1:0] span;
    logic signed [2*VW+1:0] rise;
    logic signed [2*VW+1:0] run;
    logic signed [2*VW+1:0] quot;
    logic signed [2*VW+1:0] total;
    r.y  = '0;
    r.st = pli_pkg::ST_OK;
    // Clamp the count: below 2 acts as 2, above the table size as the table size.
    n = (count_reg < 5'd2) ? 2 : (count_reg > 5'd16) ? NODES : int'(count_reg);
    if (qx < x_knots[0] || qx > x_knots[n-1]) begin
      r.st = pli_pkg::ST_RANGE;
    end else begin
      // Walk to the first interval whose upper node is not below the query,
      // never past the last interval in use.
      seg = 0;
      while (seg < n - 2 && qx > x_knots[seg+1]) seg++;
      if (x_knots[seg+1] == x_knots[seg]) begin
        r.st = pli_pkg::ST_DEGEN;
      end else begin
        run  = x_knots[seg+1] - x_knots[seg];
        rise = y_knots[seg+1] - y_knots[seg];
        span = qx - x_knots[seg];
        quot = (span * rise) / run;
        if (quot > VAL_MAX) quot = VAL_MAX;
        if (quot < VAL_MIN) quot = VAL_MIN;
        total = y_knots[seg] + quot;
        if (total > VAL_MAX) total = VAL_MAX;
        if (total < VAL_MIN) total = VAL_MIN;
        r.y = total[VW-1:0];
      end
    end
    return r;
  endfunction

  // Command driver: pop the next beat, hold it until the core takes it, then
  // update the shadow table or queue the predicted result, and draw the
  // idle gap before the next beat. The gap only counts down while the core
  // is not busy, so it lands after a query finishes rather than hiding
  // behind it; a zero gap raises start early and the beat waits on busy.
  int          gap_cnt = 0;
  bit          no_idle = 1'b0;
  interp_cmd_t cur_cmd;

  always @(posedge clk) begin : cmd_driver
    bit          taken;
    interp_res_t want;
    taken = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (taken) begin
        if (cur_cmd.op == pli_pkg::OP_WRITE) begin
          x_knots[cur_cmd.idx] = cur_cmd.nx;
          y_knots[cur_cmd.idx] = cur_cmd.ny;
        end else begin
          want = interp_predict(cur_cmd.qx);
          expected_results.push_back(want);
        end
        taken_cnt++;
        // Flip now and then into a stretch of back-to-back beats.
        if ($urandom_range(0, 47) == 0) no_idle = !no_idle;
        gap_cnt = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (!start || taken) begin
        if (gap_cnt > 0) begin
          if (!busy) gap_cnt--;
          start <= 1'b0;
        end else if (queued_cmds.size() != 0) begin
          cur_cmd = queued_cmds.pop_front();
          op         <= cur_cmd.op;
          node_index <= cur_cmd.idx;
          node_x     <= cur_cmd.nx;
          node_y     <= cur_cmd.ny;
          query_x    <= cur_cmd.qx;
          start      <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result checker: every strobed beat must match the oldest prediction.
  always @(posedge clk) begin : result_check
    interp_res_t want;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing pending: result_y %0d status %0d", result_y, status);
        fail_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (result_y !== want.y) begin
          $error("result_y: expected %0d, got %0d", $signed(want.y), result_y);
          fail_cnt++;
        end
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_write(input int idx, input logic [VW-1:0] xv, input logic [VW-1:0] yv);
    interp_cmd_t c;
    c.op  = pli_pkg::OP_WRITE;
    c.idx = idx[3:0];
    c.nx  = xv;
    c.ny  = yv;
    c.qx  = $urandom;
    plan_x[idx] = xv;
    queued_cmds.push_back(c);
    issued_cnt++;
  endtask

  task automatic push_query(input logic [VW-1:0] qv);
    interp_cmd_t c;
    c.op  = pli_pkg::OP_QUERY;
    c.idx = 4'($urandom);
    c.nx  = $urandom;
    c.ny  = $urandom;
    c.qx  = qv;
    queued_cmds.push_back(c);
    issued_cnt++;
  endtask

  // Queue a fresh ascending table: random start, random spacing at a random
  // scale (clamped at the top, which may leave repeated abscissas there),
  // sometimes a zero-width first interval. Ordinates are random, smooth,
  // alternating full scale, or near the rails. Write only the nodes in use
  // or the whole table, in ascending or descending index order.
  task automatic load_table(input int ne);
    logic [VW-1:0] xs [NODES];
    logic [VW-1:0] ys [NODES];
    longint        xv;
    longint        yv;
    int            bits;
    int            y_mode;
    int            phase_bit;
    int            top;
    int            rev;
    int            idx;
    int            i;
    bits = $urandom_range(0, 28);
    if (bits > 23) begin
      xv = VAL_MIN + longint'($urandom_range(0, 65535));
    end else begin
      xv = longint'($signed($urandom));
    end
    for (i = 0; i < NODES; i++) begin
      xs[i] = xv[VW-1:0];
      xv = xv + longint'($urandom_range(0, 1 << bits));
      if (xv > VAL_MAX) xv = VAL_MAX;
    end
    if ($urandom_range(0, 5) == 0) xs[1] = xs[0];
    y_mode    = $urandom_range(0, 3);
    phase_bit = $urandom_range(0, 1);
    yv        = longint'($signed($urandom));
    for (i = 0; i < NODES; i++) begin
      case (y_mode)
        0: ys[i] = $urandom;
        1: begin
          yv = yv + longint'($urandom_range(0, 1 << 20)) - longint'(1 << 19);
          if (yv > VAL_MAX) yv = VAL_MAX;
          if (yv < VAL_MIN) yv = VAL_MIN;
          ys[i] = yv[VW-1:0];
        end
        2: ys[i] = ((i + phase_bit) % 2 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        default: begin
          if ($urandom_range(0, 1) != 0) ys[i] = 32'h7FFF_FFFF - 32'($urandom_range(0, 255));
          else ys[i] = 32'h8000_0000 + 32'($urandom_range(0, 255));
        end
      endcase
    end
    top = ($urandom_range(0, 3) == 0) ? NODES - 1 : ne - 1;
    rev = $urandom_range(0, 1);
    for (i = 0; i <= top; i++) begin
      idx = (rev != 0) ? top - i : i;
      push_write(idx, xs[idx], ys[idx]);
    end
  endtask

  // Aim a query: mostly inside the table span, often right on a node or one
  // step off it, sometimes just outside either end, sometimes anywhere.
  function automatic logic [VW-1:0] pick_query(input int ne);
    longint lo;
    longint hi;
    longint q;
    int     k;
    lo = plan_x[0];
    hi = plan_x[ne-1];
    k  = $urandom_range(0, ne - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (hi >= lo) q = lo + longint'($urandom_range(0, 32'(hi - lo)));
        else q = longint'($signed($urandom));
      end
      4, 5:    q = plan_x[k];
      6:       q = longint'(plan_x[k]) + (($urandom_range(0, 1) != 0) ? 64'sd1 : -64'sd1);
      7:       q = longint'($signed($urandom));
      8:       q = lo - longint'($urandom_range(1, 1 << $urandom_range(0, 24)));
      default: q = hi + longint'($urandom_range(1, 1 << $urandom_range(0, 24)));
    endcase
    if (q > VAL_MAX) q = VAL_MAX;
    if (q < VAL_MIN) q = VAL_MIN;
    return q[VW-1:0];
  endfunction

  // Write the node count while the core is idle; the shadow copy follows
  // at the beat.
  task automatic write_node_count(input logic [4:0] v);
    @(posedge clk);
    cfg_valid  <= 1'b1;
    node_count <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_reg = v;
  endtask

  // Drain: every queued beat taken, every predicted result seen, then let a
  // trailing write or query settle.
  task automatic wait_idle();
    while (taken_cnt != issued_cnt || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    int p;
    int i;
    int ne;
    int budget;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      write_node_count(5'(count_plan[p]));
      ne = (count_plan[p] < 2) ? 2 : (count_plan[p] > NODES) ? NODES : count_plan[p];
      budget = issued_cnt + ITEMS_PER_PHASE;

      if (p == 0) begin
        // Fill the whole table first so no later query reads an unwritten node.
        // Nodes 0 and 1 share an abscissa; 2..3 rise rail to rail over a
        // tiny step and 3..4 fall back, so the quotient saturates both ways.
        for (i = 0; i < NODES; i++) begin
          case (i)
            0:       push_write(i, 32'h8000_0000, 32'h1234_5678);
            1:       push_write(i, 32'h8000_0000, 32'h7FFF_FFFF);
            2:       push_write(i, 32'hC000_0000, 32'h8000_0000);
            3:       push_write(i, 32'hC001_0000, 32'h7FFF_FFFF);
            4:       push_write(i, 32'hE000_0000, 32'h8000_0000);
            15:      push_write(i, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            default: push_write(i, 32'((i - 5) << 24), $urandom);
          endcase
        end
        push_query(32'h8000_0000);   // on the shared abscissa: zero-width interval
        push_query(32'hC001_0000);   // top of the full-scale rise
        push_query(32'hC000_8000);   // middle of the full-scale rise
        push_query(32'hD000_0000);   // inside the full-scale fall
        push_query(32'hE000_0000);   // exactly on an interior node
        push_query(32'h0400_0000);
        push_query(32'h0880_0001);
        push_query(32'h7FFF_FFFF);   // last node, most positive input
        push_write(0, 32'h8000_0001, 32'h0000_0000);
        push_query(32'h8000_0000);   // one below the first node
        push_write(15, 32'h7FFF_FFFE, 32'h8000_0000);
        push_query(32'h7FFF_FFFF);   // one above the last node
      end

      // Mostly well-formed tables followed by a burst of queries; now and
      // then a stray node write scrambles the order before the queries.
      while (issued_cnt < budget) begin
        load_table(ne);
        if ($urandom_range(0, 3) == 0) push_write($urandom_range(0, NODES - 1), $urandom, $urandom);
        repeat ($urandom_range(3, 14)) push_query(pick_query(ne));
      end
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: piecewise_linear_interpolator_core.f
hdl/pli_pkg.sv
hdl/pli_cell.sv
hdl/pli_muldiv.sv
hdl/piecewise_linear_interpolator_core.sv
sim/tb.sv
